[rtl/string_intern_pool_defines.svh]
// Assertion macros for the string intern pool RTL, included by sip_back.
// Assertions sample on clk and are disabled while arst_n is low.
`ifndef STRING_INTERN_POOL_DEFINES_SVH
`define STRING_INTERN_POOL_DEFINES_SVH
`ifndef ASSERT_OFF
`define SIP_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("string intern pool assertion failed");
`define SIP_IMPLY(lbl, ante, cons) `SIP_ASSERT(lbl, (ante) |-> (cons))
`else
`define SIP_ASSERT(lbl, prop)
`define SIP_IMPLY(lbl, ante, cons)
`endif
`endif

[rtl/sip_pkg.sv]
// Package for the string intern pool: sizes, register codes, job and state types.
// Has no dependencies; used by every RTL file of the block but sip_ram.
`default_nettype none
package sip_pkg;
	localparam int POOL_BYTES_DEF     = 4096;
	localparam int MAX_STRING_LEN_DEF = 255;
	localparam int LEN_W              = 9;
	localparam int CFG_W              = 13;
	localparam int OFS_W              = 12;
	localparam logic [CFG_W-1:0] POOL_LIMIT_RESET = 13'd4096;
	localparam logic REG_POOL_LIMIT = 1'b0;

	// One terminated string handed from the front to the back.
	typedef struct packed {
		logic [7:0] len;
		logic       too_long;
	} job_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HDR_RD,
		S_HDR,
		S_CMP_RD,
		S_CMP,
		S_APPEND_CHK,
		S_WR_LEN,
		S_BUF_RD,
		S_WR_CH,
		S_WR_TERM,
		S_RESULT
	} back_state_t;
endpackage
`default_nettype wire

[rtl/sip_ram.sv]
// Generic single-write, single-read RAM with a registered read.
// Used for the pool store and the string buffer; no dependencies.
`default_nettype none
module sip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/sip_front.sv]
// Front part: collects characters into the string buffer and queues a job on the terminator.
// Depends on sip_pkg and sip_ram.
`default_nettype none
module sip_front import sip_pkg::*; #(
	parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEF,
	localparam int BW = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    char_byte,
	input  wire logic          busy,
	output logic               job_push,
	output job_t               job_data,
	input  wire logic [BW-1:0] buf_raddr,
	output logic      [7:0]    buf_rdata
);
	localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_STRING_LEN);

	logic [LEN_W-1:0] len_q;
	logic             accept;
	logic             is_term;
	logic             buf_we;

	// New characters wait while an earlier string still owns the buffer.
	assign in_stall = busy;
	assign accept   = in_valid && !in_stall;
	assign is_term  = (char_byte == 8'd0);
	assign buf_we   = accept && !is_term && (len_q < MAXL);

	assign job_push          = accept && is_term;
	assign job_data.len      = len_q[7:0];
	assign job_data.too_long = (len_q > MAXL);

	// Length counts up to one past the maximum to mark overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (accept) begin
			if (is_term) begin
				len_q <= '0;
			end else if (len_q <= MAXL) begin
				len_q <= len_q + LEN_W'(1);
			end
		end
	end

	sip_ram #(.WIDTH(8), .DEPTH(MAX_STRING_LEN)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (len_q[BW-1:0]),
		.wdata (char_byte),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);
endmodule
`default_nettype wire

[rtl/sip_fifo.sv]
// Two-entry job queue between the front and the back.
// Depends on sip_pkg.
`default_nettype none
module sip_fifo import sip_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_data,
	input  wire logic pop,
	output job_t      head,
	output logic      not_empty
);
	job_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign head      = slot_q[rd_q];
	assign not_empty = (count_q != 2'd0);

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

[rtl/sip_back.sv]
// Back part: walks the pool for a match, appends new strings, and holds the result item.
// Depends on sip_pkg and sip_ram; assertions come from string_intern_pool_defines.svh.
`include "string_intern_pool_defines.svh"
`default_nettype none
module sip_back import sip_pkg::*; #(
	parameter int POOL_BYTES     = POOL_BYTES_DEF,
	parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEF,
	localparam int AW = $clog2(POOL_BYTES),
	localparam int BW = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CFG_W-1:0] pool_limit,
	input  job_t                  job_head,
	input  wire logic             job_avail,
	output logic                  job_pop,
	output logic                  busy,
	output logic      [BW-1:0]    buf_raddr,
	input  wire logic [7:0]       buf_rdata,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  found_existing,
	output logic      [OFS_W-1:0] string_offset,
	output logic                  pool_full,
	output logic                  too_long
);
	localparam int PW = AW + 1;
	localparam int CW = ((PW > CFG_W) ? PW : CFG_W) + 2;

	back_state_t state_q, state_d;
	job_t        job_q, job_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [PW-1:0] fill_q, fill_d;
	logic [7:0]    k_q, k_d;
	logic          r_found_q, r_found_d;
	logic          r_full_q, r_full_d;
	logic          r_long_q, r_long_d;
	logic [PW-1:0] r_where_q, r_where_d;

	logic          pool_we;
	logic [AW-1:0] pool_waddr;
	logic [7:0]    pool_wdata;
	logic [AW-1:0] pool_raddr;
	logic [7:0]    pool_rdata;

	logic [PW-1:0] next_entry;
	logic          last_k;
	logic [CW-1:0] limit;
	logic [CW-1:0] need_end;
	logic          load_out;
	logic [PW+OFS_W-1:0] where_ext;

	assign next_entry = pos_q + PW'(job_q.len) + PW'(2);
	assign last_k     = ({1'b0, k_q} + 9'd1) == {1'b0, job_q.len};
	assign limit      = (CW'(pool_limit) < CW'(POOL_BYTES)) ? CW'(pool_limit) : CW'(POOL_BYTES);
	assign need_end   = CW'(fill_q) + CW'(job_q.len) + CW'(2);
	assign busy       = (state_q != S_IDLE);
	assign where_ext  = (PW+OFS_W)'(r_where_q);

	// Sequencer: next state, memory ports and result capture.
	always_comb begin
		state_d    = state_q;
		job_d      = job_q;
		pos_d      = pos_q;
		fill_d     = fill_q;
		k_d        = k_q;
		r_found_d  = r_found_q;
		r_full_d   = r_full_q;
		r_long_d   = r_long_q;
		r_where_d  = r_where_q;
		job_pop    = 1'b0;
		pool_we    = 1'b0;
		pool_waddr = fill_q[AW-1:0];
		pool_wdata = job_q.len;
		pool_raddr = pos_q[AW-1:0];
		buf_raddr  = k_q[BW-1:0];
		load_out   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (job_avail) begin
					job_pop   = 1'b1;
					job_d     = job_head;
					pos_d     = '0;
					r_found_d = 1'b0;
					r_full_d  = 1'b0;
					r_long_d  = job_head.too_long;
					r_where_d = '0;
					state_d   = job_head.too_long ? S_RESULT : S_HDR_RD;
				end
			end
			S_HDR_RD: begin
				state_d = (pos_q < fill_q) ? S_HDR : S_APPEND_CHK;
			end
			S_HDR: begin
				if (pool_rdata == job_q.len) begin
					k_d = '0;
					if (job_q.len == 8'd0) begin
						r_found_d = 1'b1;
						r_where_d = pos_q + PW'(1);
						state_d   = S_RESULT;
					end else begin
						state_d = S_CMP_RD;
					end
				end else begin
					pos_d   = pos_q + PW'(pool_rdata) + PW'(2);
					state_d = S_HDR_RD;
				end
			end
			S_CMP_RD: begin
				pool_raddr = AW'(pos_q + PW'(1) + PW'(k_q));
				state_d    = S_CMP;
			end
			S_CMP: begin
				if (pool_rdata != buf_rdata) begin
					pos_d   = next_entry;
					state_d = S_HDR_RD;
				end else if (last_k) begin
					r_found_d = 1'b1;
					r_where_d = pos_q + PW'(1);
					state_d   = S_RESULT;
				end else begin
					k_d     = k_q + 8'd1;
					state_d = S_CMP_RD;
				end
			end
			S_APPEND_CHK: begin
				k_d = '0;
				if (need_end <= limit) begin
					state_d = S_WR_LEN;
				end else begin
					r_full_d = 1'b1;
					state_d  = S_RESULT;
				end
			end
			S_WR_LEN: begin
				pool_we = 1'b1;
				state_d = (job_q.len == 8'd0) ? S_WR_TERM : S_BUF_RD;
			end
			S_BUF_RD: begin
				state_d = S_WR_CH;
			end
			S_WR_CH: begin
				pool_we    = 1'b1;
				pool_waddr = AW'(fill_q + PW'(1) + PW'(k_q));
				pool_wdata = buf_rdata;
				k_d        = k_q + 8'd1;
				state_d    = last_k ? S_WR_TERM : S_BUF_RD;
			end
			S_WR_TERM: begin
				pool_we    = 1'b1;
				pool_waddr = AW'(fill_q + PW'(1) + PW'(job_q.len));
				pool_wdata = 8'd0;
				r_where_d  = fill_q + PW'(1);
				fill_d     = fill_q + PW'(job_q.len) + PW'(2);
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid || !out_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			fill_q    <= fill_d;
			out_valid <= (out_valid && out_stall) || load_out;
		end
	end

	// Working and result payload registers.
	always_ff @(posedge clk) begin
		job_q     <= job_d;
		pos_q     <= pos_d;
		k_q       <= k_d;
		r_found_q <= r_found_d;
		r_full_q  <= r_full_d;
		r_long_q  <= r_long_d;
		r_where_q <= r_where_d;
		if (load_out) begin
			found_existing <= r_found_q;
			string_offset  <= where_ext[OFS_W-1:0];
			pool_full      <= r_full_q;
			too_long       <= r_long_q;
		end
	end

	sip_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_pool (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.raddr (pool_raddr),
		.rdata (pool_rdata)
	);

	`SIP_ASSERT(a_fill_in_pool, fill_q <= PW'(POOL_BYTES))
	`SIP_IMPLY(a_one_flag, out_valid, $onehot0({found_existing, pool_full, too_long}))
	`SIP_IMPLY(a_fill_moves_on_append, fill_q != $past(fill_q), $past(state_q) == S_WR_TERM)
	`SIP_IMPLY(a_pop_only_idle, job_pop, state_q == S_IDLE && job_avail)
endmodule
`default_nettype wire

[rtl/string_intern_pool.sv]
// String intern pool top level. A character item is accepted whenever in_stall is low.
// For a terminator item the back walks the entry headers, compares the bytes of each entry of
// matching length, and appends a string not found if it fits. The single read port of the
// pool RAM bounds the rate by the pool bytes walked; input stalls until the result is loaded.
// Reset clears the fill pointer and length and sets the limit register to 4096 at once;
// pool and buffer contents are never read before being written.
`default_nettype none
module string_intern_pool import sip_pkg::*; #(
	parameter int POOL_BYTES     = POOL_BYTES_DEF,
	parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       char_byte,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  found_existing,
	output logic      [OFS_W-1:0] string_offset,
	output logic                  pool_full,
	output logic                  too_long
);
	localparam int BW = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1;

	logic [CFG_W-1:0] pool_limit_q;
	logic             busy;
	logic             back_busy;
	logic             job_push;
	job_t             job_data;
	logic             job_pop;
	job_t             job_head;
	logic             job_avail;
	logic [BW-1:0]    buf_raddr;
	logic [7:0]       buf_rdata;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_POOL_LIMIT) ? {{(32-CFG_W){1'b0}}, pool_limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_limit_q <= POOL_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_POOL_LIMIT) begin
			pool_limit_q <= pwdata[CFG_W-1:0];
		end
	end

	assign busy = job_avail || back_busy;

	sip_front #(.MAX_STRING_LEN(MAX_STRING_LEN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_byte (char_byte),
		.busy      (busy),
		.job_push  (job_push),
		.job_data  (job_data),
		.buf_raddr (buf_raddr),
		.buf_rdata (buf_rdata)
	);

	sip_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_data),
		.pop       (job_pop),
		.head      (job_head),
		.not_empty (job_avail)
	);

	sip_back #(.POOL_BYTES(POOL_BYTES), .MAX_STRING_LEN(MAX_STRING_LEN)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pool_limit     (pool_limit_q),
		.job_head       (job_head),
		.job_avail      (job_avail),
		.job_pop        (job_pop),
		.busy           (back_busy),
		.buf_raddr      (buf_raddr),
		.buf_rdata      (buf_rdata),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found_existing (found_existing),
		.string_offset  (string_offset),
		.pool_full      (pool_full),
		.too_long       (too_long)
	);
endmodule
`default_nettype wire

[bench/string_intern_pool_checker.sv]
// Checker for the string intern pool: watches the config port and both item channels.
// Predicts each lookup result and compares it field by field. Depends on sip_pkg.
`default_nettype none
module string_intern_pool_checker import sip_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  char_byte,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        found_existing,
	input  wire logic [11:0] string_offset,
	input  wire logic        pool_full,
	input  wire logic        too_long,
	output int               fail_count,
	output int               pending
);
	typedef struct packed {
		logic        found;
		logic [11:0] offset;
		logic        full;
		logic        overlong;
	} lookup_t;

	// Shadow copy of the pool, the string being collected and the limit register.
	logic [7:0]       shadow_pool [POOL_BYTES_DEF];
	logic [7:0]       collect_buf [MAX_STRING_LEN_DEF];
	int unsigned      fill_ptr;
	int unsigned      collect_len;
	int unsigned      limit_reg;
	lookup_t          lookup_q [$];

	function automatic logic [7:0] pool_byte(int unsigned addr);
		return (addr < POOL_BYTES_DEF) ? shadow_pool[addr] : 8'd0;
	endfunction

	// Searches the shadow pool for the collected string, appending it when new.
	function automatic lookup_t intern_string(int unsigned len);
		lookup_t     res;
		int unsigned pos;
		int unsigned entry_len;
		int unsigned cap;
		bit          same;
		res = '0;
		if (len > MAX_STRING_LEN_DEF) begin
			res.overlong = 1'b1;
			return res;
		end
		pos = 0;
		while (pos < fill_ptr) begin
			entry_len = pool_byte(pos);
			if (entry_len == len) begin
				same = 1'b1;
				for (int k = 0; k < len; k++)
					if (pool_byte(pos + 1 + k) != collect_buf[k]) begin
						same = 1'b0;
						break;
					end
				if (same) begin
					res.found = 1'b1;
					res.offset = 12'(pos + 1);
					return res;
				end
			end
			pos += entry_len + 2;
		end
		cap = (limit_reg < POOL_BYTES_DEF) ? limit_reg : POOL_BYTES_DEF;
		if (fill_ptr + len + 2 <= cap) begin
			shadow_pool[fill_ptr] = 8'(len);
			for (int k = 0; k < len; k++)
				shadow_pool[fill_ptr + 1 + k] = collect_buf[k];
			shadow_pool[fill_ptr + 1 + len] = 8'd0;
			res.offset = 12'(fill_ptr + 1);
			fill_ptr += len + 2;
		end else begin
			res.full = 1'b1;
		end
		return res;
	endfunction

	task automatic report(string field, int got, int want);
		$display("mismatch in %s at %0t: got %0d, expected %0d", field, $time, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Track register writes, predict on accepted items and compare results.
	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			fill_ptr = 0;
			collect_len = 0;
			limit_reg = POOL_LIMIT_RESET;
			lookup_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_POOL_LIMIT)
				limit_reg = pwdata[CFG_W-1:0];
			if (in_valid && !in_stall) begin
				if (char_byte != 8'd0) begin
					if (collect_len < MAX_STRING_LEN_DEF)
						collect_buf[collect_len] = char_byte;
					if (collect_len <= MAX_STRING_LEN_DEF)
						collect_len++;
				end else begin
					lookup_q.push_back(intern_string(collect_len));
					collect_len = 0;
				end
			end
			if (out_valid && !out_stall) begin
				if (lookup_q.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					want = lookup_q.pop_front();
					if (found_existing !== want.found)
						report("found_existing", found_existing, want.found);
					if (string_offset !== want.offset)
						report("string_offset", string_offset, want.offset);
					if (pool_full !== want.full)
						report("pool_full", pool_full, want.full);
					if (too_long !== want.overlong)
						report("too_long", too_long, want.overlong);
				end
			end
		end
		pending = lookup_q.size();
	end
endmodule
`default_nettype wire

[bench/string_intern_pool_test.sv]
// Top of the string intern pool bench: clock, reset, stimulus and the verdict.
// Depends on sip_pkg, string_intern_pool and string_intern_pool_checker.
`default_nettype none
module string_intern_pool_test;
	import sip_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [7:0]  char_byte;
	logic        out_valid, out_stall;
	logic        found_existing, pool_full, too_long;
	logic [11:0] string_offset;
	int          fail_count, pending;

	int          idle_pct, stall_pct, hold_left, items_sent;
	logic [7:0]  vocab [24][$];

	string_intern_pool u_dut (.*);

	string_intern_pool_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound on the slowest correct run, several times over.
	initial begin
		#200_000_000;
		$display("[string_intern_pool] ERROR");
		$finish;
	end

	// Receiver: random stalls, with one long hold-off.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offers one character item and waits until it is accepted.
	task automatic send_byte(logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic send_string(logic [7:0] chars [$]);
		foreach (chars[i])
			send_byte(chars[i]);
		send_byte(8'd0);
	endtask

	function automatic void random_string(int len, ref logic [7:0] s [$]);
		s.delete();
		for (int i = 0; i < len; i++)
			s.push_back(8'($urandom_range(255, 1)));
	endfunction

	// Waits until every expected result has come and the block has settled.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly words from a small vocabulary so that lookups hit, plus fresh, long and overlong strings.
	task automatic random_phase(int n_items);
		logic [7:0] s [$];
		int         stop_at;
		int         pick;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 75)
				s = vocab[$urandom_range(23)];
			else if (pick < 95)
				random_string($urandom_range(8), s);
			else if (pick < 98)
				random_string($urandom_range(255, 20), s);
			else
				random_string($urandom_range(262, 256), s);
			send_string(s);
		end
	endtask

	initial begin
		logic [7:0] s [$];
		logic [7:0] t [$];
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		char_byte = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		items_sent = 0;
		foreach (vocab[i])
			random_string($urandom_range(6), vocab[i]);
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n = 1'b1;

		// Directed: empty string twice, extreme bytes, longest and overlong strings, a two-byte string.
		s.delete();
		send_string(s);
		send_string(s);
		s = '{8'hFF};
		send_string(s);
		s = '{8'h01};
		send_string(s);
		s = '{8'hFF};
		send_string(s);
		random_string(MAX_STRING_LEN_DEF, t);
		send_string(t);
		random_string(MAX_STRING_LEN_DEF + 1, s);
		send_string(s);
		s = '{8'h41, 8'h42};
		send_string(s);
		drain();

		// Ignored write to an unused address, then full speed.
		write_reg(3'd4, 32'd1);
		random_phase(50);

		// Sender idle often; the receiver then holds off while items keep coming.
		idle_pct = 46;
		random_phase(30);
		hold_left = 1500;
		random_phase(60);
		drain();

		// Limit of 1: every new string is full, pooled ones still found.
		write_reg(3'd0, 32'd1);
		idle_pct = 0;
		stall_pct = 46;
		s.delete();
		send_string(s);
		send_string(t);
		random_phase(40);
		drain();

		// Largest register value, clipped to the pool size.
		write_reg(3'd0, 32'h1FFF);
		idle_pct = 13;
		stall_pct = 13;
		random_phase(50);
		drain();

		// Limit of 700, then back to the reset value.
		write_reg(3'd0, 32'd700);
		idle_pct = 46;
		stall_pct = 46;
		random_phase(30);
		drain();
		write_reg(3'd0, 32'd4096);
		idle_pct = 0;
		stall_pct = 0;
		random_phase(50);
		drain();

		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[string_intern_pool] OK");
		else
			$display("[string_intern_pool] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
+incdir+rtl
rtl/sip_pkg.sv
rtl/sip_ram.sv
rtl/sip_front.sv
rtl/sip_fifo.sv
rtl/sip_back.sv
rtl/string_intern_pool.sv
bench/string_intern_pool_checker.sv
bench/string_intern_pool_test.sv
